>>> rtl/core/swenc_pkg.sv
`default_nettype none

package swenc_pkg;

    // field widths of the two channels
    localparam int KIND_W  = 5;
    localparam int VALUE_W = 33;
    localparam int SYM_W   = 2;

    // widest magnitude the symbol run can carry
    localparam int MAG_LIMIT = 32;

    typedef logic [SYM_W-1:0]  t_sym;
    typedef logic [KIND_W-1:0] t_kind;
    typedef logic [2:0]        t_sel;

    // emitted symbols
    localparam t_sym SYM_SP  = 2'd0;
    localparam t_sym SYM_TAB = 2'd1;
    localparam t_sym SYM_LF  = 2'd2;

    // opcodes
    localparam t_kind OP_PUSH   = 5'd0;
    localparam t_kind OP_DUPE   = 5'd1;
    localparam t_kind OP_COPY   = 5'd2;
    localparam t_kind OP_SWAP   = 5'd3;
    localparam t_kind OP_DROP   = 5'd4;
    localparam t_kind OP_SLIDE  = 5'd5;
    localparam t_kind OP_ADD    = 5'd6;
    localparam t_kind OP_SUB    = 5'd7;
    localparam t_kind OP_MUL    = 5'd8;
    localparam t_kind OP_DIV    = 5'd9;
    localparam t_kind OP_MOD    = 5'd10;
    localparam t_kind OP_STORE  = 5'd11;
    localparam t_kind OP_FETCH  = 5'd12;
    localparam t_kind OP_MARK   = 5'd13;
    localparam t_kind OP_CALL   = 5'd14;
    localparam t_kind OP_JMP    = 5'd15;
    localparam t_kind OP_JZ     = 5'd16;
    localparam t_kind OP_JN     = 5'd17;
    localparam t_kind OP_RET    = 5'd18;
    localparam t_kind OP_END    = 5'd19;
    localparam t_kind OP_PRINTC = 5'd20;
    localparam t_kind OP_PRINTI = 5'd21;
    localparam t_kind OP_READC  = 5'd22;
    localparam t_kind OP_READI  = 5'd23;
    localparam t_kind OP_COUNT  = 5'd24;

    // output symbol source
    localparam t_sel SEL_PFX  = 3'd0;
    localparam t_sel SEL_SIGN = 3'd1;
    localparam t_sel SEL_BIT  = 3'd2;
    localparam t_sel SEL_LF   = 3'd3;
    localparam t_sel SEL_ERR  = 3'd4;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic adv_pfx;
        logic shift;
        t_sel sel;
        logic last;
        logic bad;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic bad;
        logic takes_arg;
        logic pfx_last;
        logic bit_last;
        logic mag_ready;
    } t_stat;

    // ops that append a signed argument
    function automatic logic takes_arg(input t_kind kind);
        logic res;
        case (kind) inside
            OP_PUSH, OP_COPY, OP_SLIDE, OP_MARK,
            OP_CALL, OP_JMP, OP_JZ, OP_JN: res = 1'b1;
            default:                       res = 1'b0;
        endcase
        return res;
    endfunction

    // index of the final prefix symbol (length minus one)
    function automatic logic [1:0] pfx_end(input t_kind kind);
        logic [1:0] res;
        case (kind) inside
            OP_PUSH:                                          res = 2'd1;
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD,
            OP_PRINTC, OP_PRINTI, OP_READC, OP_READI:         res = 2'd3;
            default:                                          res = 2'd2;
        endcase
        return res;
    endfunction

    // prefix symbols, first symbol in the top bits
    function automatic logic [4*SYM_W-1:0] pfx_word(input t_kind kind);
        logic [4*SYM_W-1:0] res;
        case (kind)
            OP_PUSH:   res = {SYM_SP,  SYM_SP,  SYM_SP,  SYM_SP };
            OP_DUPE:   res = {SYM_SP,  SYM_LF,  SYM_SP,  SYM_SP };
            OP_COPY:   res = {SYM_SP,  SYM_TAB, SYM_SP,  SYM_SP };
            OP_SWAP:   res = {SYM_SP,  SYM_LF,  SYM_TAB, SYM_SP };
            OP_DROP:   res = {SYM_SP,  SYM_LF,  SYM_LF,  SYM_SP };
            OP_SLIDE:  res = {SYM_SP,  SYM_TAB, SYM_LF,  SYM_SP };
            OP_ADD:    res = {SYM_TAB, SYM_SP,  SYM_SP,  SYM_SP };
            OP_SUB:    res = {SYM_TAB, SYM_SP,  SYM_SP,  SYM_TAB};
            OP_MUL:    res = {SYM_TAB, SYM_SP,  SYM_SP,  SYM_LF };
            OP_DIV:    res = {SYM_TAB, SYM_SP,  SYM_TAB, SYM_SP };
            OP_MOD:    res = {SYM_TAB, SYM_SP,  SYM_TAB, SYM_TAB};
            OP_STORE:  res = {SYM_TAB, SYM_TAB, SYM_SP,  SYM_SP };
            OP_FETCH:  res = {SYM_TAB, SYM_TAB, SYM_TAB, SYM_SP };
            OP_MARK:   res = {SYM_LF,  SYM_SP,  SYM_SP,  SYM_SP };
            OP_CALL:   res = {SYM_LF,  SYM_SP,  SYM_TAB, SYM_SP };
            OP_JMP:    res = {SYM_LF,  SYM_SP,  SYM_LF,  SYM_SP };
            OP_JZ:     res = {SYM_LF,  SYM_TAB, SYM_SP,  SYM_SP };
            OP_JN:     res = {SYM_LF,  SYM_TAB, SYM_TAB, SYM_SP };
            OP_RET:    res = {SYM_LF,  SYM_TAB, SYM_LF,  SYM_SP };
            OP_END:    res = {SYM_LF,  SYM_LF,  SYM_LF,  SYM_SP };
            OP_PRINTC: res = {SYM_TAB, SYM_LF,  SYM_SP,  SYM_SP };
            OP_PRINTI: res = {SYM_TAB, SYM_LF,  SYM_SP,  SYM_TAB};
            OP_READC:  res = {SYM_TAB, SYM_LF,  SYM_TAB, SYM_SP };
            OP_READI:  res = {SYM_TAB, SYM_LF,  SYM_TAB, SYM_TAB};
            default:   res = {SYM_SP,  SYM_SP,  SYM_SP,  SYM_SP };
        endcase
        return res;
    endfunction

    // one prefix symbol by position
    function automatic t_sym pfx_sym(input t_kind kind, input logic [1:0] idx);
        logic [4*SYM_W-1:0] word;
        t_sym               res;
        word = pfx_word(kind);
        case (idx)
            2'd0:    res = word[4*SYM_W-1:3*SYM_W];
            2'd1:    res = word[3*SYM_W-1:2*SYM_W];
            2'd2:    res = word[2*SYM_W-1:SYM_W];
            default: res = word[SYM_W-1:0];
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/swenc_in_if.sv
`default_nettype none

interface swenc_in_if import swenc_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [KIND_W-1:0]         kind;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, kind, value, input ready);
    modport sink   (input valid, kind, value, output ready);
endinterface

`default_nettype wire

>>> rtl/core/swenc_out_if.sv
`default_nettype none

interface swenc_out_if import swenc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] symbol;
    logic             last;
    logic             bad_op;

    modport source (output valid, symbol, last, bad_op, input ready);
    modport sink   (input valid, symbol, last, bad_op, output ready);
endinterface

`default_nettype wire

>>> rtl/core/swenc_ctrl.sv
`default_nettype none

module swenc_ctrl import swenc_pkg::*; (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  wire   i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CHK  = 3'd1;
    localparam logic [2:0] ST_PFX  = 3'd2;
    localparam logic [2:0] ST_SIGN = 3'd3;
    localparam logic [2:0] ST_BITS = 3'd4;
    localparam logic [2:0] ST_LF   = 3'd5;
    localparam logic [2:0] ST_ERR  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       w_take;

    assign w_take = o_out_valid && i_out_ready;

    // sequence one instruction: check, then an error word, or prefix and, for argument ops, sign, bits, linefeed
    always_comb begin
        n_state       = r_state;
        o_in_ready    = 1'b0;
        o_out_valid   = 1'b0;
        o_cmd         = '0;
        o_cmd.sel     = SEL_ERR;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CHK;
                end
            end
            ST_CHK: begin
                n_state = i_stat.bad ? ST_ERR : ST_PFX;
            end
            ST_ERR: begin
                o_out_valid = 1'b1;
                o_cmd.sel   = SEL_ERR;
                o_cmd.last  = 1'b1;
                o_cmd.bad   = 1'b1;
                if (w_take) begin
                    n_state = ST_IDLE;
                end
            end
            ST_PFX: begin
                o_out_valid = 1'b1;
                o_cmd.sel   = SEL_PFX;
                o_cmd.last  = i_stat.pfx_last && !i_stat.takes_arg;
                if (w_take) begin
                    o_cmd.adv_pfx = 1'b1;
                    if (i_stat.pfx_last) begin
                        n_state = i_stat.takes_arg ? ST_SIGN : ST_IDLE;
                    end
                end
            end
            ST_SIGN: begin
                o_out_valid = 1'b1;
                o_cmd.sel   = SEL_SIGN;
                if (w_take) begin
                    n_state = ST_BITS;
                end
            end
            ST_BITS: begin
                // hold until the leading-zero scan is done
                o_out_valid = i_stat.mag_ready;
                o_cmd.sel   = SEL_BIT;
                if (w_take) begin
                    o_cmd.shift = 1'b1;
                    if (i_stat.bit_last) begin
                        n_state = ST_LF;
                    end
                end
            end
            ST_LF: begin
                o_out_valid = 1'b1;
                o_cmd.sel   = SEL_LF;
                o_cmd.last  = 1'b1;
                if (w_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid)
        else $error("input ready while a word is offered");

    a_check_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_out_valid)
        else $error("word offered in the cycle after accept");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && o_cmd.last) |=> o_in_ready)
        else $error("not idle after the final word");

    a_bad_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_cmd.bad) |-> o_cmd.last)
        else $error("error word is not the final word");
`endif

endmodule

`default_nettype wire

>>> rtl/core/swenc_dp.sv
`default_nettype none

module swenc_dp import swenc_pkg::*; #(
    parameter int VALUE_BITS = 32
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  t_cmd                      i_cmd,
    input  wire [KIND_W-1:0]          i_kind,
    input  wire signed [VALUE_W-1:0]  i_value,
    output t_stat                     o_stat,
    output logic [SYM_W-1:0]          o_symbol,
    output logic                      o_last,
    output logic                      o_bad_op
);

    localparam int MAG_W = (VALUE_BITS < MAG_LIMIT) ? VALUE_BITS : MAG_LIMIT;
    localparam int CNT_W = $clog2(MAG_W + 1);

    logic [VALUE_W-1:0] w_raw;
    logic [VALUE_W-1:0] w_mag;
    logic               w_ovf;

    t_kind              r_kind;
    logic               r_neg;
    logic               r_ovf;
    logic [MAG_W-1:0]   r_mag;
    logic [MAG_W-1:0]   n_mag;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   n_cnt;
    logic               r_norm;
    logic               n_norm;
    logic [1:0]         r_idx;
    logic [1:0]         n_idx;

    // magnitude of the argument and its overflow past the bit budget
    assign w_raw = $unsigned(i_value);
    assign w_mag = w_raw[VALUE_W-1] ? (VALUE_W'(0) - w_raw) : w_raw;
    assign w_ovf = |(w_mag >> MAG_W);

    // scan off leading zeros one bit a cycle, then shift out on command
    always_comb begin
        n_mag  = r_mag;
        n_cnt  = r_cnt;
        n_norm = r_norm;
        n_idx  = r_idx;
        if (i_cmd.load) begin
            n_mag  = w_mag[MAG_W-1:0];
            n_cnt  = CNT_W'(MAG_W);
            n_norm = 1'b0;
            n_idx  = 2'd0;
        end else begin
            if (!r_norm) begin
                if (r_cnt == CNT_W'(1) || r_mag[MAG_W-1]) begin
                    n_norm = 1'b1;
                end else begin
                    n_mag = r_mag << 1;
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end else if (i_cmd.shift) begin
                n_mag = r_mag << 1;
                n_cnt = r_cnt - CNT_W'(1);
            end
            if (i_cmd.adv_pfx) begin
                n_idx = r_idx + 2'd1;
            end
        end
    end

    // hold the instruction payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_neg  <= w_raw[VALUE_W-1];
            r_ovf  <= w_ovf;
        end
        r_mag <= n_mag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_norm <= 1'b0;
            r_idx  <= 2'd0;
        end else begin
            r_cnt  <= n_cnt;
            r_norm <= n_norm;
            r_idx  <= n_idx;
        end
    end

    // status for the controller
    always_comb begin
        o_stat.takes_arg = takes_arg(r_kind);
        o_stat.bad       = (r_kind >= OP_COUNT) || (takes_arg(r_kind) && r_ovf);
        o_stat.pfx_last  = (r_idx == pfx_end(r_kind));
        o_stat.bit_last  = (r_cnt == CNT_W'(1));
        o_stat.mag_ready = r_norm;
    end

    // select the symbol on offer
    always_comb begin
        unique case (i_cmd.sel)
            SEL_PFX:  o_symbol = pfx_sym(r_kind, r_idx);
            SEL_SIGN: o_symbol = r_neg ? SYM_TAB : SYM_SP;
            SEL_BIT:  o_symbol = r_mag[MAG_W-1] ? SYM_TAB : SYM_SP;
            SEL_LF:   o_symbol = SYM_LF;
            default:  o_symbol = SYM_SP;
        endcase
    end

    assign o_last   = i_cmd.last;
    assign o_bad_op = i_cmd.bad;

endmodule

`default_nettype wire

>>> rtl/core/stack_op_whitespace_encoder.sv
// Encodes one stack-machine instruction as a run of whitespace symbols.
// Input channel i_in carries kind (opcode) and a signed 33-bit value; a word
// is taken when valid and ready are both high. Output channel o_out carries
// one symbol per word (0 space, 1 tab, 2 linefeed), with last on the final
// symbol of the run and bad_op on an error word.
// An invalid opcode, or an argument whose magnitude needs more than
// VALUE_BITS (at most 32) bits, gives a single space word with last and
// bad_op set and no prefix.
// One instruction is handled at a time: ready is high only while idle.
// The first symbol is offered after accept once the check state has passed,
// then one symbol per cycle while the receiver takes them and, for magnitude
// bits, once the scan is done. A run is 2 to 4 prefix symbols, plus sign,
// magnitude bits and linefeed for argument ops. The leading-zero scan of the
// magnitude drops one bit a cycle, overlapped with check, prefix and sign;
// small magnitudes can make the first magnitude bit wait for the scan.
// A stalled receiver holds the offered word unchanged. Reset returns the
// controller to idle and drops any run in progress.
`default_nettype none

module stack_op_whitespace_encoder import swenc_pkg::*; #(
    parameter int VALUE_BITS = 32
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    swenc_in_if.sink     i_in,
    swenc_out_if.source  o_out
);

    t_cmd  w_cmd;
    t_stat w_stat;

    swenc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    swenc_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_kind   (i_in.kind),
        .i_value  (i_in.value),
        .o_stat   (w_stat),
        .o_symbol (o_out.symbol),
        .o_last   (o_out.last),
        .o_bad_op (o_out.bad_op)
    );

endmodule

`default_nettype wire
